FILE: hw/rtl/dcs_pkg.sv
// ---------------------------------------------------------------------------
// dcs_pkg
// Shared types and constants for the discrete CDF sampler.
// ---------------------------------------------------------------------------
package dcs_pkg;

    localparam int CUM_W   = 24;
    localparam int WEIGHT_W = 16;
    localparam int VALUE_W = 32;
    localparam int PICK_W  = 17;
    localparam int INDEX_W = 8;
    localparam int OP_W    = 2;
    localparam int STATUS_W = 2;

    localparam logic [CUM_W-1:0] CUM_MAX = {CUM_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_DRAW   = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_VALUE
    } state_t;

endpackage

FILE: hw/rtl/discrete_cdf_sampler.sv
// ---------------------------------------------------------------------------
// discrete_cdf_sampler
// Inverse-CDF discrete sampler over a table of (value, cumulative weight).
// ---------------------------------------------------------------------------
// Usage:
//   An item is taken at a rising edge with start high and busy low. Every
//   item gives exactly one result, shown for one cycle with done high; the
//   receiver cannot stall, so results must be captured on that cycle.
//   Clear, append, unused codes and errors (full table, empty draw) answer
//   in the cycle after acceptance and keep busy low, so a new item may be
//   issued every cycle.
//   A draw scans the cumulative memory one entry per cycle starting at
//   entry 0 and stops at the chosen index k, at most TABLE_DEPTH-1, then
//   reads the value memory; done rises once that value is registered.
//   The scan rate is set by the single read port of the cumulative memory.
//   Busy is high for the whole draw.
//   Reset empties the table (entry count and running sum to zero); the
//   memories themselves are not cleared, since only written entries are
//   ever used.
// ---------------------------------------------------------------------------
module discrete_cdf_sampler
    import dcs_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [OP_W-1:0]           operation,
    input  logic [WEIGHT_W-1:0]       entry_weight,
    input  logic signed [VALUE_W-1:0] entry_value,
    input  logic [PICK_W-1:0]         pick,
    output logic                      done,
    output logic [INDEX_W-1:0]        sample_index,
    output logic signed [VALUE_W-1:0] sample_value,
    output logic [STATUS_W-1:0]       status
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(TABLE_DEPTH);

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CUM_W-1:0]      last_cum_reg, last_cum_next;
    logic [IW-1:0]         addr_reg, addr_next;
    logic [PICK_W-1:0]     pick_reg, pick_next;
    logic                  done_reg, done_next;
    logic [INDEX_W-1:0]    index_reg, index_next;
    logic [VALUE_W-1:0]    value_reg, value_next;
    logic [STATUS_W-1:0]   status_reg, status_next;

    logic                  accept;
    op_t                   op;
    logic                  full;
    logic                  empty;
    logic                  hit;
    logic [CUM_W:0]        sum_wide;
    logic [CUM_W-1:0]      sum_sat;
    logic                  cum_we;
    logic [IW-1:0]         cum_raddr;
    logic [CUM_W-1:0]      cum_rdata;
    logic [VALUE_W-1:0]    val_rdata;

    assign accept = start && (state_reg == S_IDLE);
    assign op     = op_t'(operation);
    assign full   = (count_reg == COUNT_FULL);
    assign empty  = (count_reg == '0);

    // saturating running sum of weights
    assign sum_wide = {1'b0, last_cum_reg} + (CUM_W + 1)'(entry_weight);
    assign sum_sat  = sum_wide[CUM_W] ? CUM_MAX : sum_wide[CUM_W-1:0];

    // last valid entry is taken when nothing reaches the pick
    assign hit = (cum_rdata >= CUM_W'(pick_reg))
              || (addr_reg == IW'(count_reg - CW'(1)));

    assign cum_we    = accept && (op == OP_APPEND) && !full;
    assign cum_raddr = (state_reg == S_SCAN) ? IW'(addr_reg + IW'(1)) : '0;

    dcs_ram #(
        .WIDTH (CUM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_cum_ram (
        .clk   (clk),
        .we    (cum_we),
        .waddr (IW'(count_reg)),
        .wdata (sum_sat),
        .raddr (cum_raddr),
        .rdata (cum_rdata)
    );

    dcs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_val_ram (
        .clk   (clk),
        .we    (cum_we),
        .waddr (IW'(count_reg)),
        .wdata (entry_value),
        .raddr (addr_reg),
        .rdata (val_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (op == OP_DRAW) && !empty)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    state_next = S_VALUE;
                end
            end
            S_VALUE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next    = count_reg;
        last_cum_next = last_cum_reg;
        addr_next     = addr_reg;
        pick_next     = pick_reg;
        done_next     = 1'b0;
        index_next    = '0;
        value_next    = '0;
        status_next   = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    case (op)
                        OP_CLEAR:
                        begin
                            count_next    = '0;
                            last_cum_next = '0;
                        end
                        OP_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next    = count_reg + CW'(1);
                                last_cum_next = sum_sat;
                            end
                        end
                        OP_DRAW:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                done_next = 1'b0;
                                addr_next = '0;
                                pick_next = pick;
                            end
                        end
                        default:
                        begin
                            // unused code: all-zero answer
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (!hit)
                begin
                    addr_next = IW'(addr_reg + IW'(1));
                end
            end
            S_VALUE:
            begin
                done_next  = 1'b1;
                index_next = INDEX_W'(addr_reg);
                value_next = val_rdata;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            last_cum_reg <= '0;
            done_reg     <= 1'b0;
            index_reg    <= '0;
            value_reg    <= '0;
            status_reg   <= ST_OK;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            last_cum_reg <= last_cum_next;
            done_reg     <= done_next;
            index_reg    <= index_next;
            value_reg    <= value_next;
            status_reg   <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        pick_reg <= pick_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign sample_index = index_reg;
    assign sample_value = value_reg;
    assign status       = status_reg;

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_FULL)
        else $error("entry count beyond table depth");

    a_empty_draw: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == OP_DRAW) && empty) |=> (done && (status == ST_EMPTY)))
        else $error("draw on empty table not flagged");

    a_draw_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VALUE) |=> (done && (status == ST_OK) && !busy))
        else $error("draw did not complete after value read");

    a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CW'(addr_reg) < count_reg))
        else $error("scan past last valid entry");

endmodule

FILE: hw/rtl/dcs_ram.sv
// ---------------------------------------------------------------------------
// dcs_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ---------------------------------------------------------------------------
module dcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
